// ----- sv/tnc_pkg.sv -----
// tnc_pkg: shared types and constants for the triangle normal core
// no dependencies
`timescale 1ns / 1ps

package tnc_pkg;

	localparam int OUT_W = 32;

	localparam logic [1:0] AXIS_Z = 2'd0;
	localparam logic [1:0] AXIS_X = 2'd1;
	localparam logic [1:0] AXIS_Y = 2'd2;

	typedef struct packed {
		logic       found;
		logic [1:0] axis;
		logic       neg_u;
		logic       neg_v;
	} meta_t;

endpackage

// ----- sv/tnc_cross.sv -----
// tnc_cross: edge vectors, partial products and cross product, three stages
// depends on tnc_pkg
`timescale 1ns / 1ps

module tnc_cross #(
	parameter int CW = 16,
	localparam int EW = CW + 1,
	localparam int PW = 2 * EW,
	localparam int CRW = PW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [CW-1:0]  p1_x,
	input  logic signed [CW-1:0]  p1_y,
	input  logic signed [CW-1:0]  p1_z,
	input  logic signed [CW-1:0]  p2_x,
	input  logic signed [CW-1:0]  p2_y,
	input  logic signed [CW-1:0]  p2_z,
	input  logic signed [CW-1:0]  p3_x,
	input  logic signed [CW-1:0]  p3_y,
	input  logic signed [CW-1:0]  p3_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [CRW-1:0] c1,
	output logic signed [CRW-1:0] c2,
	output logic signed [CRW-1:0] c3
);
	import tnc_pkg::*;

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;
	logic signed [EW-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PW-1:0] ay_bz_s2, az_by_s2, az_bx_s2, ax_bz_s2, ax_by_s2, ay_bx_s2;
	logic signed [CRW-1:0] c1_s3, c2_s3, c3_s3;

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// edges
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= EW'(p2_x) - EW'(p1_x);
			ay_s1 <= EW'(p2_y) - EW'(p1_y);
			az_s1 <= EW'(p2_z) - EW'(p1_z);
			bx_s1 <= EW'(p3_x) - EW'(p1_x);
			by_s1 <= EW'(p3_y) - EW'(p1_y);
			bz_s1 <= EW'(p3_z) - EW'(p1_z);
		end
	end

	// partial products
	always_ff @(posedge clk) begin
		if (en2) begin
			ay_bz_s2 <= PW'(ay_s1) * PW'(bz_s1);
			az_by_s2 <= PW'(az_s1) * PW'(by_s1);
			az_bx_s2 <= PW'(az_s1) * PW'(bx_s1);
			ax_bz_s2 <= PW'(ax_s1) * PW'(bz_s1);
			ax_by_s2 <= PW'(ax_s1) * PW'(by_s1);
			ay_bx_s2 <= PW'(ay_s1) * PW'(bx_s1);
		end
	end

	// cross product
	always_ff @(posedge clk) begin
		if (en3) begin
			c1_s3 <= CRW'(ay_bz_s2) - CRW'(az_by_s2);
			c2_s3 <= CRW'(az_bx_s2) - CRW'(ax_bz_s2);
			c3_s3 <= CRW'(ax_by_s2) - CRW'(ay_bx_s2);
		end
	end

	assign out_valid = v_s3;
	assign c1 = c1_s3;
	assign c2 = c2_s3;
	assign c3 = c3_s3;

endmodule

// ----- sv/tnc_select.sv -----
// tnc_select: picks the pinned axis and forms rounded dividends, two stages
// depends on tnc_pkg
`timescale 1ns / 1ps

module tnc_select #(
	parameter int CW = 16,
	parameter int FRAC = 16,
	localparam int MW = 2 * (CW + 1) + 1,
	localparam int NW = MW + FRAC + 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [MW-1:0]  c1,
	input  logic signed [MW-1:0]  c2,
	input  logic signed [MW-1:0]  c3,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NW-1:0]         num_u,
	output logic [NW-1:0]         num_v,
	output logic [MW:0]           den,
	output tnc_pkg::meta_t        meta
);
	import tnc_pkg::*;

	logic en1, en2;
	logic v_s1, v_s2;
	logic signed [MW-1:0] sel_b, sel_u, sel_v;
	meta_t sel_meta;
	logic [MW-1:0] mag_b_s1, mag_u_s1, mag_v_s1;
	meta_t meta_s1, meta_s2;
	logic [NW-1:0] num_u_s2, num_v_s2;
	logic [MW:0] den_s2;

	assign en2 = !v_s2 || !out_stall;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	// normal is the cross product divided by its pinned component
	always_comb begin
		sel_meta.found = 1'b1;
		if (c3 != '0) begin
			sel_meta.axis = AXIS_Z;
			sel_b = c3;
			sel_u = c1;
			sel_v = c2;
		end else if (c1 != '0) begin
			sel_meta.axis = AXIS_X;
			sel_b = c1;
			sel_u = c2;
			sel_v = c3;
		end else if (c2 != '0) begin
			sel_meta.axis = AXIS_Y;
			sel_b = c2;
			sel_u = c1;
			sel_v = c3;
		end else begin
			sel_meta.found = 1'b0;
			sel_meta.axis = AXIS_Z;
			sel_b = '0;
			sel_u = '0;
			sel_v = '0;
		end
		sel_meta.neg_u = (sel_u != '0) && (sel_u[MW-1] != sel_b[MW-1]);
		sel_meta.neg_v = (sel_v != '0) && (sel_v[MW-1] != sel_b[MW-1]);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			meta_s1 <= sel_meta;
			mag_b_s1 <= sel_b[MW-1] ? MW'(-sel_b) : MW'(sel_b);
			mag_u_s1 <= sel_u[MW-1] ? MW'(-sel_u) : MW'(sel_u);
			mag_v_s1 <= sel_v[MW-1] ? MW'(-sel_v) : MW'(sel_v);
		end
	end

	// round half away: (2|a| 2^f + |b|) / 2|b|
	always_ff @(posedge clk) begin
		if (en2) begin
			meta_s2 <= meta_s1;
			num_u_s2 <= (NW'(mag_u_s1) << (FRAC + 1)) + NW'(mag_b_s1);
			num_v_s2 <= (NW'(mag_v_s1) << (FRAC + 1)) + NW'(mag_b_s1);
			den_s2 <= {mag_b_s1, 1'b0};
		end
	end

	assign out_valid = v_s2;
	assign num_u = num_u_s2;
	assign num_v = num_v_s2;
	assign den = den_s2;
	assign meta = meta_s2;

endmodule

// ----- sv/tnc_div.sv -----
// tnc_div: two-lane pipelined restoring divider, one quotient bit per stage,
// with range check, saturation and sign; depends on tnc_pkg
`timescale 1ns / 1ps

module tnc_div #(
	parameter int CW = 16,
	parameter int FRAC = 16,
	localparam int MW = 2 * (CW + 1) + 1,
	localparam int NW = MW + FRAC + 34
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [NW-1:0]              num_u,
	input  logic [NW-1:0]              num_v,
	input  logic [MW:0]                den,
	input  tnc_pkg::meta_t             meta,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tnc_pkg::OUT_W-1:0]  quot_u,
	output logic [tnc_pkg::OUT_W-1:0]  quot_v,
	output logic                       found,
	output logic [1:0]                 axis,
	output logic                       saturated
);
	import tnc_pkg::*;

	localparam int NST = OUT_W + 2;

	logic en [0:NST];
	logic v_s [0:NST-1];
	logic [NW-1:0] ru_s [0:OUT_W];
	logic [NW-1:0] rv_s [0:OUT_W];
	logic [OUT_W-1:0] qu_s [0:OUT_W];
	logic [OUT_W-1:0] qv_s [0:OUT_W];
	logic [MW:0] den_s [0:OUT_W];
	meta_t meta_s [0:OUT_W];
	logic ovu_s [0:OUT_W];
	logic ovv_s [0:OUT_W];
	logic [OUT_W-1:0] lim_u, lim_v, mag_u, mag_v;
	logic sat_u, sat_v;
	logic [OUT_W-1:0] quot_u_q, quot_v_q;
	logic found_q, sat_q;
	logic [1:0] axis_q;

	assign en[NST] = !v_s[NST-1] || !out_stall;
	assign in_stall = !en[0];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_ctl
			logic v_in;
			if (k == 0) begin : g_first
				assign v_in = in_valid;
			end else begin : g_next
				assign v_in = v_s[k-1];
			end
			assign en[k] = !v_s[k] || en[k+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_in;
				end
			end
		end
	endgenerate

	// quotient must fit in the output word
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ru_s[0] <= num_u;
			rv_s[0] <= num_v;
			qu_s[0] <= '0;
			qv_s[0] <= '0;
			den_s[0] <= den;
			meta_s[0] <= meta;
			ovu_s[0] <= num_u >= (NW'(den) << OUT_W);
			ovv_s[0] <= num_v >= (NW'(den) << OUT_W);
		end
	end

	generate
		for (k = 1; k <= OUT_W; k++) begin : g_step
			logic [NW-1:0] dsh;
			logic ge_u, ge_v;
			assign dsh = NW'(den_s[k-1]) << (OUT_W - k);
			assign ge_u = ru_s[k-1] >= dsh;
			assign ge_v = rv_s[k-1] >= dsh;
			always_ff @(posedge clk) begin
				if (en[k]) begin
					ru_s[k] <= ge_u ? ru_s[k-1] - dsh : ru_s[k-1];
					rv_s[k] <= ge_v ? rv_s[k-1] - dsh : rv_s[k-1];
					qu_s[k] <= {qu_s[k-1][OUT_W-2:0], ge_u};
					qv_s[k] <= {qv_s[k-1][OUT_W-2:0], ge_v};
					den_s[k] <= den_s[k-1];
					meta_s[k] <= meta_s[k-1];
					ovu_s[k] <= ovu_s[k-1];
					ovv_s[k] <= ovv_s[k-1];
				end
			end
		end
	endgenerate

	always_comb begin
		lim_u = meta_s[OUT_W].neg_u ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		lim_v = meta_s[OUT_W].neg_v ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		sat_u = ovu_s[OUT_W] || (qu_s[OUT_W] > lim_u);
		sat_v = ovv_s[OUT_W] || (qv_s[OUT_W] > lim_v);
		mag_u = sat_u ? lim_u : qu_s[OUT_W];
		mag_v = sat_v ? lim_v : qv_s[OUT_W];
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			found_q <= meta_s[OUT_W].found;
			axis_q <= meta_s[OUT_W].axis;
			sat_q <= meta_s[OUT_W].found && (sat_u || sat_v);
			if (!meta_s[OUT_W].found) begin
				quot_u_q <= '0;
				quot_v_q <= '0;
			end else begin
				quot_u_q <= meta_s[OUT_W].neg_u ? -mag_u : mag_u;
				quot_v_q <= meta_s[OUT_W].neg_v ? -mag_v : mag_v;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign quot_u = quot_u_q;
	assign quot_v = quot_v_q;
	assign found = found_q;
	assign axis = axis_q;
	assign saturated = sat_q;

endmodule

// ----- sv/triangle_normal_by_cramer_core.sv -----
// triangle_normal_by_cramer_core: triangle surface normal in fixed point
// depends on tnc_pkg, tnc_cross, tnc_select, tnc_div
//
//  channel | handshake          | payload
//  input   | in_valid, in_stall | p1_x .. p3_z, COORD_WIDTH bits, Q8.8
//  output  | out_valid, out_stall | norm_x/y/z Q16.16, found, pinned_axis, saturated
//
// one triangle per cycle while out_stall is low; in order: edges and cross product,
// then axis choice and dividends, then the divider (one quotient bit a stage)
// every stage holds its own valid bit, so bubbles close up under out_stall
// reset clears the valid bits only
`timescale 1ns / 1ps

module triangle_normal_by_cramer_core #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS_OUT = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [COORD_WIDTH-1:0]          p1_x,
	input  logic signed [COORD_WIDTH-1:0]          p1_y,
	input  logic signed [COORD_WIDTH-1:0]          p1_z,
	input  logic signed [COORD_WIDTH-1:0]          p2_x,
	input  logic signed [COORD_WIDTH-1:0]          p2_y,
	input  logic signed [COORD_WIDTH-1:0]          p2_z,
	input  logic signed [COORD_WIDTH-1:0]          p3_x,
	input  logic signed [COORD_WIDTH-1:0]          p3_y,
	input  logic signed [COORD_WIDTH-1:0]          p3_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [tnc_pkg::OUT_W-1:0]       norm_x,
	output logic signed [tnc_pkg::OUT_W-1:0]       norm_y,
	output logic signed [tnc_pkg::OUT_W-1:0]       norm_z,
	output logic                                   found,
	output logic [1:0]                             pinned_axis,
	output logic                                   saturated
);
	import tnc_pkg::*;

	localparam int MW = 2 * (COORD_WIDTH + 1) + 1;
	localparam int NW = MW + FRAC_BITS_OUT + 34;
	localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_BITS_OUT;

	logic cr_valid, cr_stall, se_valid, se_stall;
	logic signed [MW-1:0] c1, c2, c3;
	logic [NW-1:0] num_u, num_v;
	logic [MW:0] den;
	meta_t meta;
	logic [OUT_W-1:0] quot_u, quot_v;
	logic dv_found;
	logic [1:0] dv_axis;

	tnc_cross #(.CW(COORD_WIDTH)) u_cross (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.p3_x(p3_x), .p3_y(p3_y), .p3_z(p3_z),
		.out_valid(cr_valid), .out_stall(cr_stall),
		.c1(c1), .c2(c2), .c3(c3)
	);

	tnc_select #(.CW(COORD_WIDTH), .FRAC(FRAC_BITS_OUT)) u_select (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cr_valid), .in_stall(cr_stall),
		.c1(c1), .c2(c2), .c3(c3),
		.out_valid(se_valid), .out_stall(se_stall),
		.num_u(num_u), .num_v(num_v), .den(den), .meta(meta)
	);

	tnc_div #(.CW(COORD_WIDTH), .FRAC(FRAC_BITS_OUT)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(se_valid), .in_stall(se_stall),
		.num_u(num_u), .num_v(num_v), .den(den), .meta(meta),
		.out_valid(out_valid), .out_stall(out_stall),
		.quot_u(quot_u), .quot_v(quot_v),
		.found(dv_found), .axis(dv_axis), .saturated(saturated)
	);

	// place the pinned component
	always_comb begin
		norm_x = '0;
		norm_y = '0;
		norm_z = '0;
		if (dv_found) begin
			case (dv_axis)
				AXIS_X: begin
					norm_x = ONE;
					norm_y = quot_u;
					norm_z = quot_v;
				end
				AXIS_Y: begin
					norm_x = quot_u;
					norm_y = ONE;
					norm_z = quot_v;
				end
				default: begin
					norm_x = quot_u;
					norm_y = quot_v;
					norm_z = ONE;
				end
			endcase
		end
	end

	assign found = dv_found;
	assign pinned_axis = dv_axis;

endmodule
